[src/oriented_box_support_and_bounds_macros.svh]
// Assertion macros for the oriented box block.
`ifndef ORIENTED_BOX_SUPPORT_AND_BOUNDS_MACROS_SVH
`define ORIENTED_BOX_SUPPORT_AND_BOUNDS_MACROS_SVH
`ifndef ASSERT_OFF
`define OBX_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define OBX_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define OBX_ASSERT(label, clk, rst_n, prop)
`define OBX_ASSERT_RST(label, clk, prop)
`endif
`endif

[src/obx_pkg.sv]
package obx_pkg;
  localparam int QF = 14;
  localparam int NSTG = 6;
  localparam logic [2:0] REG_QUAT = 3'd0;
  localparam logic [2:0] REG_CX = 3'd1;
  localparam logic [2:0] REG_CY = 3'd2;
  localparam logic [2:0] REG_CZ = 3'd3;
  localparam logic [2:0] REG_HX = 3'd4;
  localparam logic [2:0] REG_HY = 3'd5;
  localparam logic [2:0] REG_HZ = 3'd6;

  // A non-unit quaternion can push an entry up to about sixteen times one.
  typedef logic signed [19:0] ment_t;
  typedef ment_t mat_t [3][3];

  typedef struct packed {
    logic signed [31:0] cx, cy, cz;
    logic [30:0] hx, hy, hz;
  } pose_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

[src/obx_matrix.sv]
// Rotation matrix from the quaternion register, registered. The quaternion is
// to change only while the block is idle (the block does not enforce this), so the pipeline sees it as a constant.
module obx_matrix (
  input  logic clk,
  input  logic [63:0] quat,
  output obx_pkg::mat_t m_r
);
  import obx_pkg::*;
  logic signed [15:0] w, x, y, z;
  logic signed [33:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [33:0] one;
  mat_t m_nxt;

  assign w = quat[15:0];
  assign x = quat[31:16];
  assign y = quat[47:32];
  assign z = quat[63:48];
  assign one = 34'sd1 <<< (2 * QF);

  function automatic ment_t ent(input logic signed [33:0] base, input logic signed [33:0] p2);
    logic signed [35:0] s;
    s = 36'(base) + (36'(p2) <<< 1) + (36'sd1 <<< (QF - 1));
    return ment_t'(s >>> QF);
  endfunction

  always_comb begin
    p_xx = 34'(x * x); p_yy = 34'(y * y); p_zz = 34'(z * z);
    p_xy = 34'(x * y); p_xz = 34'(x * z); p_yz = 34'(y * z);
    p_wx = 34'(w * x); p_wy = 34'(w * y); p_wz = 34'(w * z);
    m_nxt[0][0] = ent(one, -(p_yy + p_zz));
    m_nxt[0][1] = ent('0, p_xy - p_wz);
    m_nxt[0][2] = ent('0, p_xz + p_wy);
    m_nxt[1][0] = ent('0, p_xy + p_wz);
    m_nxt[1][1] = ent(one, -(p_xx + p_zz));
    m_nxt[1][2] = ent('0, p_yz - p_wx);
    m_nxt[2][0] = ent('0, p_xz - p_wy);
    m_nxt[2][1] = ent('0, p_yz + p_wx);
    m_nxt[2][2] = ent(one, -(p_xx + p_yy));
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end
endmodule

[src/obx_pipe.sv]
// Six-stage datapath: local products, local signs, support products,
// sums with rounding, bound scaling, saturation.
module obx_pipe (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_v,
  input  logic [111:0] in_d,
  input  obx_pkg::mat_t m,
  input  obx_pkg::pose_t pose,
  output logic [obx_pkg::NSTG-1:0] vld_r,
  output logic [293:0] res
);
  import obx_pkg::*;
  typedef logic signed [51:0] prod_t;
  typedef logic signed [63:0] wide_t;

  // Stage 1: products of matrix columns with the direction.
  prod_t p1_r [3][3];
  logic [15:0] sc1_r, sc2_r, sc3_r, sc4_r;
  logic signed [31:0] d [3];
  // Stage 2: local signs.
  logic signed [1:0] sg2_r [3];
  // Stage 3: support products and radius products.
  prod_t q3_r [3][3];
  logic [48:0] a3_r [3][3];
  logic signed [1:0] sg3_r [3], sg4_r [3], sg5_r [3];
  // Stage 4: rounded sums.
  wide_t s4_r [3];
  logic [42:0] r4_r [3];
  // Stage 5: scaled radius.
  wide_t s5_r [3];
  logic [58:0] sc5_r [3];
  // Stage 6: output words.
  logic [293:0] res_r;
  logic [NSTG-1:0] vld_nxt;

  assign d[0] = in_d[31:0];
  assign d[1] = in_d[63:32];
  assign d[2] = in_d[95:64];

  function automatic logic [30:0] hsel(input int j, input pose_t p);
    return j == 0 ? p.hx : (j == 1 ? p.hy : p.hz);
  endfunction
  function automatic logic signed [31:0] csel(input int j, input pose_t p);
    return j == 0 ? p.cx : (j == 1 ? p.cy : p.cz);
  endfunction

  // Valid bits advance with the data.
  assign vld_nxt = {vld_r[NSTG-2:0], in_v};
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wide_t t;
      logic [50:0] u;
      logic [63:0] z;
      sc1_r <= in_d[111:96]; sc2_r <= sc1_r; sc3_r <= sc2_r; sc4_r <= sc3_r;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p1_r[i][j] <= prod_t'(m[j][i]) * prod_t'(d[j]);
      for (int i = 0; i < 3; i++) begin
        t = 64'(p1_r[i][0]) + 64'(p1_r[i][1]) + 64'(p1_r[i][2]);
        sg2_r[i] <= t > 0 ? 2'sd1 : (t < 0 ? -2'sd1 : 2'sd0);
      end
      for (int i = 0; i < 3; i++) begin
        sg3_r[i] <= sg2_r[i];
        for (int j = 0; j < 3; j++) begin
          q3_r[i][j] <= sg2_r[j] == 2'sd0 ? '0 :
            (sg2_r[j] > 0 ? prod_t'(m[i][j]) * prod_t'({1'b0, hsel(j, pose)})
                          : -(prod_t'(m[i][j]) * prod_t'({1'b0, hsel(j, pose)})));
          a3_r[i][j] <= 49'(m[i][j] < 0 ? -m[i][j] : m[i][j]) * 49'(hsel(j, pose));
        end
      end
      for (int i = 0; i < 3; i++) begin
        sg4_r[i] <= sg3_r[i];
        t = 64'(q3_r[i][0]) + 64'(q3_r[i][1]) + 64'(q3_r[i][2]) + (64'sd1 <<< (QF - 1));
        s4_r[i] <= 64'(csel(i, pose)) + (t >>> QF);
        u = 51'(a3_r[i][0]) + 51'(a3_r[i][1]) + 51'(a3_r[i][2]) + (51'd1 << (QF - 1));
        r4_r[i] <= (u >> QF) > (51'd1 << 42) ? 43'd1 << 42 : 43'(u >> QF);
      end
      for (int i = 0; i < 3; i++) begin
        sg5_r[i] <= sg4_r[i];
        s5_r[i] <= s4_r[i];
        sc5_r[i] <= (59'(r4_r[i]) * 59'(sc4_r) + 59'd128) >> 8;
      end
      for (int i = 0; i < 3; i++) begin
        z = 64'(sc5_r[i]);
        res_r[32*i +: 32] <= sat32(s5_r[i]);
        res_r[96 + 2*i +: 2] <= sg5_r[i];
        res_r[102 + 32*i +: 32] <= sat32(64'(csel(i, pose)) - $signed(z));
        res_r[198 + 32*i +: 32] <= sat32(64'(csel(i, pose)) + $signed(z));
      end
    end
  end
  assign res = res_r;
endmodule

[src/oriented_box_support_and_bounds.sv]
// Oriented box support point and scaled bound. One query is accepted per
// cycle unless the output stalls; results pass through the six register
// stages (product, sign, product, sum, scale, saturate). The whole pipeline
// holds, and in_tready drops, while a finished result waits at the output
// with out_tready low. The user must write pose registers through the cfg
// port only while no query is in flight; the block does not enforce it.
module oriented_box_support_and_bounds (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // dir_x, dir_y, dir_z, bound_scale
  input  logic [111:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // support_x/y/z, sign_x/y/z, box_min_x/y/z, box_max_x/y/z, 2 zero bits
  output logic [295:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);
  `include "oriented_box_support_and_bounds_macros.svh"
  import obx_pkg::*;
  logic [63:0] quat_r;
  pose_t pose_r;
  mat_t m;
  logic adv;
  logic [5:0] vld;
  logic [293:0] res;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r <= 64'd16384;
      pose_r <= '{cx: '0, cy: '0, cz: '0, hx: 31'd32768, hy: 31'd32768, hz: 31'd32768};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_QUAT: quat_r <= cfg_data;
        REG_CX: pose_r.cx <= cfg_data[31:0];
        REG_CY: pose_r.cy <= cfg_data[31:0];
        REG_CZ: pose_r.cz <= cfg_data[31:0];
        REG_HX: pose_r.hx <= cfg_data[30:0];
        REG_HY: pose_r.hy <= cfg_data[30:0];
        REG_HZ: pose_r.hz <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  obx_matrix u_mat (.clk(clk), .quat(quat_r), .m_r(m));

  // Pipeline moves whenever the last stage is empty or being drained.
  assign adv = !vld[5] || out_tready;
  assign in_tready = adv;

  obx_pipe u_pipe (.clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_tvalid),
    .in_d(in_tdata), .m(m), .pose(pose_r), .vld_r(vld), .res(res));

  assign out_tvalid = vld[5];
  assign out_tdata = {2'b00, res};

  `OBX_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `OBX_ASSERT(a_ready, clk, rst_n, !out_tvalid |-> in_tready)
  `OBX_ASSERT(a_pad, clk, rst_n, out_tvalid |-> out_tdata[295:294] == 2'b00)
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import obx_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // dir_x, dir_y, dir_z, bound_scale
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // support_x/y/z, sign_x/y/z, box_min_x/y/z, box_max_x/y/z, 2 zero bits
  logic [295:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = REG_QUAT;
  logic [63:0]  cfg_data = '0;

  // Shadow copy of the pose registers
  logic [63:0]        pose_quat;
  longint             pose_center [3];
  longint             pose_half [3];

  logic [111:0] query_q [$];
  logic [295:0] bound_q [$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_on = 1'b0;
  int           hold_cnt = 0;
  int           fails = 0;

  oriented_box_support_and_bounds dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rot_entry(longint base, longint prod2);
    return (base + 2 * prod2 + (64'sd1 <<< (QF - 1))) >>> QF;
  endfunction

  // Support point, local signs and scaled bound for one query.
  function automatic logic [295:0] support_and_bounds(logic [111:0] q);
    longint m [3][3];
    longint w, x, y, z, one, acc, v [3], dir [3];
    longint unsigned uacc, r, sc;
    int sg [3];
    logic [31:0] word;
    logic [295:0] res;
    w = longint'($signed(pose_quat[15:0]));
    x = longint'($signed(pose_quat[31:16]));
    y = longint'($signed(pose_quat[47:32]));
    z = longint'($signed(pose_quat[63:48]));
    one = 64'sd1 <<< (2 * QF);
    m[0][0] = rot_entry(one, -(y * y + z * z));
    m[0][1] = rot_entry(0, x * y - w * z);
    m[0][2] = rot_entry(0, x * z + w * y);
    m[1][0] = rot_entry(0, x * y + w * z);
    m[1][1] = rot_entry(one, -(x * x + z * z));
    m[1][2] = rot_entry(0, y * z - w * x);
    m[2][0] = rot_entry(0, x * z - w * y);
    m[2][1] = rot_entry(0, y * z + w * x);
    m[2][2] = rot_entry(one, -(x * x + y * y));
    for (int i = 0; i < 3; i++) dir[i] = longint'($signed(q[32 * i +: 32]));
    res = '0;
    // Direction into the box frame through the transpose.
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += m[j][i] * dir[j];
      sg[i] = (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
      v[i] = sg[i] * pose_half[i];
      res[96 + 2 * i +: 2] = 2'(sg[i]);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      uacc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += m[i][j] * v[j];
        uacc += longint'(m[i][j] < 0 ? -m[i][j] : m[i][j]) * pose_half[j];
      end
      acc = (acc + (64'sd1 <<< (QF - 1))) >>> QF;
      word = 32'(sat_word(pose_center[i] + acc));
      res[32 * i +: 32] = word;
      r = (uacc + (64'd1 << (QF - 1))) >> QF;
      if (r > (64'd1 << 42)) r = 64'd1 << 42;
      sc = (r * longint'(q[111:96]) + 128) >> 8;
      res[102 + 32 * i +: 32] = 32'(sat_word(pose_center[i] - longint'(sc)));
      res[198 + 32 * i +: 32] = 32'(sat_word(pose_center[i] + longint'(sc)));
    end
    return res;
  endfunction

  // Query driver: holds each transaction until the block accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) bound_q.push_back(support_and_bounds(in_tdata));
      if (query_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= query_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor with random and long back-pressure.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (bound_q.size() == 0) begin
          $error("unexpected result transaction");
          fails++;
        end else begin
          logic [295:0] want;
          want = bound_q.pop_front();
          for (int f = 0; f < 12; f++) begin
            int off, wid;
            string nm;
            off = (f < 3) ? 32 * f : (f < 6) ? 96 + 2 * (f - 3) : 102 + 32 * (f - 6);
            wid = (f >= 3 && f < 6) ? 2 : 32;
            nm = (f < 3) ? "support" : (f < 6) ? "sign" : (f < 9) ? "box_min" : "box_max";
            if (((want >> off) & ((296'd1 << wid) - 1)) !=
                ((out_tdata >> off) & ((296'd1 << wid) - 1))) begin
              $error("%s_%c: expected %h, got %h", nm, 8'(120 + f % 3),
                     32'((want >> off) & ((296'd1 << wid) - 1)),
                     32'((out_tdata >> off) & ((296'd1 << wid) - 1)));
              fails++;
            end
          end
        end
      end
      if (hold_on && hold_cnt < 300) begin
        out_tready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_QUAT: pose_quat = val;
      REG_CX:   pose_center[0] = longint'($signed(val[31:0]));
      REG_CY:   pose_center[1] = longint'($signed(val[31:0]));
      REG_CZ:   pose_center[2] = longint'($signed(val[31:0]));
      REG_HX:   pose_half[0] = longint'(val[30:0]);
      REG_HY:   pose_half[1] = longint'(val[30:0]);
      REG_HZ:   pose_half[2] = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic write_pose(logic [63:0] quat, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] cz, logic [30:0] hx, logic [30:0] hy,
                            logic [30:0] hz);
    write_reg(REG_QUAT, quat);
    write_reg(REG_CX, {32'd0, cx});
    write_reg(REG_CY, {32'd0, cy});
    write_reg(REG_CZ, {32'd0, cz});
    write_reg(REG_HX, {33'd0, hx});
    write_reg(REG_HY, {33'd0, hy});
    write_reg(REG_HZ, {33'd0, hz});
  endtask

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd256;
      2: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++)
      query_q.push_back({rand_scale(), rand_dir(), rand_dir(), rand_dir()});
  endtask

  // Waits until every query has been answered, then lets the pipeline drain.
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (query_q.size() > 0 || in_tvalid || bound_q.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    pose_quat = 64'd16384;
    for (int i = 0; i < 3; i++) begin
      pose_center[i] = 0;
      pose_half[i] = 32768;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset pose: axes, zero direction and scale extremes.
    query_q.push_back({16'd256, 32'd0, 32'd0, 32'd0});
    query_q.push_back({16'd0, 32'd0, 32'd0, 32'h0001_0000});
    query_q.push_back({16'hffff, 32'd0, 32'd0, 32'hffff_0000});
    query_q.push_back({16'd256, 32'd0, 32'h0001_0000, 32'd0});
    query_q.push_back({16'd256, 32'd0, 32'hffff_0000, 32'd0});
    query_q.push_back({16'd256, 32'h0001_0000, 32'd0, 32'd0});
    query_q.push_back({16'd256, 32'hffff_0000, 32'd0, 32'd0});
    query_q.push_back({16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    query_q.push_back({16'hffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    query_q.push_back({16'd1, 32'h8000_0000, 32'h7fff_ffff, 32'd1});
    query_q.push_back({16'd255, 32'hffff_ffff, 32'd0, 32'h7fff_ffff});
    queue_random(9);
    drain();

    // Quarter turn about z, moderate pose; sender idles often.
    write_pose({16'sd11585, 16'd0, 16'd0, 16'sd11585}, 32'h0003_0000, 32'hfffe_8000,
               32'h0000_4000, 31'h0002_0000, 31'h0000_8000, 31'h0001_0000);
    send_idle_pct = 65;
    queue_random(140);
    drain();

    // Random raw quaternion; receiver stalls, with one long hold-off.
    write_pose({$urandom(), $urandom()}, $urandom(), $urandom(), $urandom(),
               31'($urandom()), 31'($urandom()), 31'($urandom()));
    send_idle_pct = 0;
    recv_stall_pct = 65;
    hold_on = 1'b1;
    queue_random(140);
    drain();

    // Extreme quaternion, centre and half extents; both sides idle.
    write_pose(64'h8000_7fff_8000_7fff, 32'h7fff_ffff, 32'h8000_0000, 32'd0,
               31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    queue_random(140);
    drain();

    // Degenerate zero quaternion and flat box, no idling.
    write_pose(64'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 31'd0, 31'd0, 31'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(100);
    drain();

    // Mixed random poses at full rate, except sender idling on the second and receiver stalls on the third.
    for (int p = 0; p < 4; p++) begin
      write_pose({$urandom(), $urandom()}, $urandom(), $urandom(), $urandom(),
                 31'($urandom_range(32'h0010_0000)), 31'($urandom()),
                 31'($urandom_range(32'h0010_0000)));
      send_idle_pct = (p == 1) ? 65 : 0;
      recv_stall_pct = (p == 2) ? 65 : 0;
      queue_random(45);
      drain();
    end

    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
